### hdl/md5_message_digest_defines.svh
// ----------------------------------------------------------------------------
// md5_message_digest_defines
// Assertion macros shared by the MD5 digest block.
// ----------------------------------------------------------------------------
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MD5_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Types, constants and step tables for the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } md5_words_t;

    localparam md5_words_t MD5_INIT = '{
        a: 32'h67452301,
        b: 32'hefcdab89,
        c: 32'h98badcfe,
        d: 32'h10325476
    };

    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [5:0] LEN_POS      = 6'd56;
    localparam logic [5:0] LAST_POS     = 6'd63;
    localparam logic [5:0] LAST_STEP    = 6'd63;
    localparam int unsigned WORD_DEPTH  = 16;
    localparam int unsigned WORD_BITS   = 32;

    // Additive constant of each step.
    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Left-rotate amount of each step.
    function automatic logic [4:0] md5_shift(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // Message word used by each step.
    function automatic logic [3:0] md5_word_sel(input logic [5:0] i);
        logic [3:0] i4;
        logic [3:0] g;
        i4 = i[3:0];
        unique case (i[5:4])
            2'd0: g = i4;
            2'd1: g = 4'(i4 * 4'd5 + 4'd1);
            2'd2: g = 4'(i4 * 4'd3 + 4'd5);
            2'd3: g = 4'(i4 * 4'd7);
            default: g = i4;
        endcase
        return g;
    endfunction

endpackage

### hdl/md5_byte_if.sv
// ----------------------------------------------------------------------------
// md5_byte_if
// Message byte channel: valid/ready with one byte and its framing flags.
// ----------------------------------------------------------------------------
interface md5_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input end_of_message, output ready);
endinterface

### hdl/md5_digest_if.sv
// ----------------------------------------------------------------------------
// md5_digest_if
// Digest channel: valid/ready with one 32-bit chaining word per item.
// ----------------------------------------------------------------------------
interface md5_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

### hdl/md5_ram.sv
// ----------------------------------------------------------------------------
// md5_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module md5_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hdl/md5_round.sv
// ----------------------------------------------------------------------------
// md5_round
// One MD5 step: round function, add, rotate, and register rename.
// ----------------------------------------------------------------------------
module md5_round import md5_pkg::*; (
    input  md5_words_t  cur,
    input  logic [5:0]  step,
    input  logic [31:0] msg_word,
    output md5_words_t  nxt
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [31:0] rot;
    logic [4:0]  s;

    always_comb
    begin
        unique case (step[5:4])
            2'd0: f = (cur.b & cur.c) | (~cur.b & cur.d);
            2'd1: f = (cur.b & cur.d) | (cur.c & ~cur.d);
            2'd2: f = cur.b ^ cur.c ^ cur.d;
            2'd3: f = cur.c ^ (cur.b | ~cur.d);
            default: f = 32'h0;
        endcase
    end

    assign s   = md5_shift(step);
    assign sum = cur.a + f + msg_word + md5_k(step);
    // s is never zero, so the right shift stays below 32
    assign rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));

    assign nxt.a = cur.d;
    assign nxt.b = cur.b + rot;
    assign nxt.c = cur.b;
    assign nxt.d = cur.c;

endmodule

### hdl/md5_message_digest.sv
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 over a byte stream, four digest words out per message.
// ----------------------------------------------------------------------------
// byte_in takes one item per cycle while ready: a byte (if byte_valid) and
// an end_of_message flag. Bytes are packed into 32-bit words in a 16-word
// block RAM. The item that fills byte 63 starts a compression that holds
// ready low through ST_LOAD, 64 steps in ST_STEP through one shared step
// unit fed by the RAM read port, and ST_FIN for the chaining add.
// An end_of_message item starts padding at one byte per cycle (0x80, zeros,
// then the 64-bit bit length), from its fill position up to byte 63, plus
// one or two compressions; the worst case pads from byte 56 and needs
// two compressions before the first digest word.
// digest_out then gives four items, A first, word_index 0..3, last_word on
// D; each waits as long as the receiver holds ready low, and ready on
// byte_in stays low until the fourth word is taken. After that the chaining
// words, bit count and fill position return to their initial values.
// Reset (rst_n low) loads the initial chaining words and clears the count.
// ----------------------------------------------------------------------------
`include "md5_message_digest_defines.svh"

module md5_message_digest import md5_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    md5_byte_if.sink     byte_in,
    md5_digest_if.source digest_out
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_STEP = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    md5_words_t  chain_reg, chain_next;
    md5_words_t  work_reg, work_next;
    logic [5:0]  step_reg, step_next;
    logic [23:0] word_buf_reg, word_buf_next;
    logic        eom_reg, eom_next;
    logic        pad_first_reg, pad_first_next;
    logic        len_block_reg, len_block_next;
    logic [1:0]  out_idx_reg, out_idx_next;

    logic        in_fire;
    logic        wr_byte_en;
    logic [7:0]  wr_byte;
    logic        ram_wr_en;
    logic [3:0]  ram_rd_addr;
    logic [31:0] ram_rd_data;
    md5_words_t  round_nxt;

    assign in_fire       = byte_in.valid && byte_in.ready;
    assign byte_in.ready = (state_reg == ST_IDLE);

    // Byte source: the input item while idle, the padding stream in ST_PAD.
    always_comb
    begin
        wr_byte_en = 1'b0;
        wr_byte    = byte_in.data_byte;
        if (state_reg == ST_IDLE)
        begin
            wr_byte_en = in_fire && byte_in.byte_valid;
        end
        else if (state_reg == ST_PAD)
        begin
            wr_byte_en = 1'b1;
            if (pad_first_reg)
            begin
                wr_byte = PAD_BYTE;
            end
            else if (len_block_reg && (fill_reg >= LEN_POS))
            begin
                wr_byte = len_reg[{fill_reg[2:0], 3'b000} +: 8];
            end
            else
            begin
                wr_byte = 8'h00;
            end
        end
    end

    assign ram_wr_en   = wr_byte_en && (fill_reg[1:0] == 2'b11);
    assign ram_rd_addr = md5_word_sel((state_reg == ST_STEP) ? 6'(step_reg + 6'd1) : 6'd0);

    md5_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_DEPTH)
    ) u_block_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (fill_reg[5:2]),
        .wr_data ({wr_byte, word_buf_reg}),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    md5_round u_round (
        .cur      (work_reg),
        .step     (step_reg),
        .msg_word (ram_rd_data),
        .nxt      (round_nxt)
    );

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        step_next      = step_reg;
        word_buf_next  = word_buf_reg;
        eom_next       = eom_reg;
        pad_first_next = pad_first_reg;
        len_block_next = len_block_reg;
        out_idx_next   = out_idx_reg;

        if (wr_byte_en)
        begin
            fill_next = fill_reg + 6'd1;
            if (fill_reg[1:0] != 2'b11)
            begin
                word_buf_next[{fill_reg[1:0], 3'b000} +: 8] = wr_byte;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (byte_in.byte_valid)
                    begin
                        len_next = len_reg + 64'd8;
                    end
                    eom_next       = byte_in.end_of_message;
                    pad_first_next = byte_in.end_of_message;
                    if (byte_in.byte_valid && (fill_reg == LAST_POS))
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (byte_in.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                pad_first_next = 1'b0;
                // length fits in this block when the marker lands before byte 56
                if (pad_first_reg && (fill_reg < LEN_POS))
                begin
                    len_block_next = 1'b1;
                end
                if (fill_reg == LAST_POS)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                work_next  = chain_reg;
                step_next  = 6'd0;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                work_next = round_nxt;
                step_next = step_reg + 6'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                chain_next.a = chain_reg.a + work_reg.a;
                chain_next.b = chain_reg.b + work_reg.b;
                chain_next.c = chain_reg.c + work_reg.c;
                chain_next.d = chain_reg.d + work_reg.d;
                if (eom_reg && len_block_reg)
                begin
                    out_idx_next = 2'd0;
                    state_next   = ST_OUT;
                end
                else if (eom_reg)
                begin
                    // marker already placed: the length goes in the next block
                    if (!pad_first_reg)
                    begin
                        len_block_next = 1'b1;
                    end
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (digest_out.ready)
                begin
                    out_idx_next = out_idx_reg + 2'd1;
                    if (out_idx_reg == 2'd3)
                    begin
                        chain_next     = MD5_INIT;
                        len_next       = 64'd0;
                        eom_next       = 1'b0;
                        len_block_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= 6'd0;
            len_reg       <= 64'd0;
            chain_reg     <= MD5_INIT;
            step_reg      <= 6'd0;
            eom_reg       <= 1'b0;
            pad_first_reg <= 1'b0;
            len_block_reg <= 1'b0;
            out_idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            chain_reg     <= chain_next;
            step_reg      <= step_next;
            eom_reg       <= eom_next;
            pad_first_reg <= pad_first_next;
            len_block_reg <= len_block_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        word_buf_reg <= word_buf_next;
    end

    assign digest_out.valid      = (state_reg == ST_OUT);
    assign digest_out.word_index = out_idx_reg;
    assign digest_out.last_word  = (out_idx_reg == 2'd3);

    always_comb
    begin
        unique case (out_idx_reg)
            2'd0: digest_out.digest_word = chain_reg.a;
            2'd1: digest_out.digest_word = chain_reg.b;
            2'd2: digest_out.digest_word = chain_reg.c;
            2'd3: digest_out.digest_word = chain_reg.d;
            default: digest_out.digest_word = chain_reg.a;
        endcase
    end

    `MD5_ASSERT_NOW(a_no_overlap, digest_out.valid, !byte_in.ready, "input taken during digest output")
    `MD5_ASSERT_NEXT(a_ready_after_last, digest_out.valid && digest_out.ready && digest_out.last_word, byte_in.ready && (len_reg == 64'd0), "block not reinitialized after digest")
    `MD5_ASSERT_NOW(a_out_block_done, digest_out.valid, (fill_reg == 6'd0) && len_block_reg, "digest emitted with partial block")
    `MD5_ASSERT_NEXT(a_load_starts_step, state_reg == ST_LOAD, (state_reg == ST_STEP) && (step_reg == 6'd0), "compression did not start at step zero")

endmodule
